// File: sv/inertial_frame_checksum_decoder_core_assert.svh
// assertion macros shared by the frame checksum decoder modules
// no dependencies; taken in by `include where checks are written
`ifndef INERTIAL_FRAME_CHECKSUM_DECODER_CORE_ASSERT_SVH
`define INERTIAL_FRAME_CHECKSUM_DECODER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define IFCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ifcd check failed");

// next-cycle implication, off during reset
`define IFCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ifcd check failed");

`endif

// File: sv/ifcd_pkg.sv
// shared types, constants and helpers of the frame checksum decoder
// no dependencies
package ifcd_pkg;

    localparam int MAX_FRAME_LEN = 256;
    localparam int WORD_COUNT    = 10;
    localparam int NUM_SLOTS     = 2;

    localparam int POS_W      = $clog2(MAX_FRAME_LEN + 1);
    localparam int END_W      = 10;
    localparam int CMP_W      = (POS_W > END_W) ? POS_W : END_W;
    localparam int WORD_IDX_W = $clog2(WORD_COUNT);
    localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_OFFSET   = 3'd3;

    localparam logic [3:0] RST_CHECKSUM_START = 4'd2;
    localparam logic [7:0] RST_FIRST_OFFSET   = 8'd7;
    localparam logic [7:0] RST_SECOND_OFFSET  = 8'd21;
    localparam logic [7:0] RST_THIRD_OFFSET   = 8'd35;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_SUM = 2'd1,
        ST_SHORT   = 2'd2
    } t_status;

    typedef struct packed {
        logic [WORD_COUNT-1:0] we;
        logic [31:0]           data;
        logic                  commit;
        t_status               status;
    } t_wr_req;

    typedef struct packed {
        logic    valid;
        t_status status;
    } t_head;

    // index of the most significant byte of word k
    function automatic logic [END_W-1:0] word_end(input int k, input logic [7:0] off1,
                                                  input logic [7:0] off2,
                                                  input logic [7:0] off3);
        logic [7:0] base;
        int         j;
        base = off3;
        j    = k - 6;
        if (k < 3) begin
            base = off1;
            j    = k;
        end else if (k < 6) begin
            base = off2;
            j    = k - 3;
        end
        return END_W'(base) + END_W'(4 * j + 3);
    endfunction

endpackage

// File: sv/ifcd_front.sv
// front end: byte intake, running sums, word capture and frame classification
// depends on ifcd_pkg
module ifcd_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic [7:0]                           i_frame_byte,
    input  logic                                 i_frame_end,
    input  logic                                 i_full,
    input  logic                                 i_cfg_we,
    input  logic [ifcd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [7:0]                           i_cfg_data,
    output ifcd_pkg::t_wr_req                    o_wr
);

    logic [3:0]                 r_cs;
    logic [7:0]                 r_off1;
    logic [7:0]                 r_off2;
    logic [7:0]                 r_off3;

    logic [7:0]                 r_sf,   n_sf;
    logic [7:0]                 r_ss,   n_ss;
    logic [7:0]                 r_prev, n_prev;
    logic [7:0]                 r_old,  n_old;
    logic [ifcd_pkg::POS_W-1:0] r_pos,  n_pos;
    logic [23:0]                r_asm,  n_asm;

    logic                       accept;
    logic [ifcd_pkg::CMP_W-1:0] pos_x;
    logic [ifcd_pkg::CMP_W-1:0] max_x;
    logic                       sum_go;
    logic [7:0]                 sf_upd;
    logic [7:0]                 ss_upd;
    logic                       in_range;
    logic                       short_frame;
    logic                       sums_ok;
    logic [ifcd_pkg::CMP_W-1:0] end_x [ifcd_pkg::WORD_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cs   <= ifcd_pkg::RST_CHECKSUM_START;
            r_off1 <= ifcd_pkg::RST_FIRST_OFFSET;
            r_off2 <= ifcd_pkg::RST_SECOND_OFFSET;
            r_off3 <= ifcd_pkg::RST_THIRD_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ifcd_pkg::CFG_CHECKSUM_START: r_cs   <= i_cfg_data[3:0];
                ifcd_pkg::CFG_FIRST_OFFSET:   r_off1 <= i_cfg_data;
                ifcd_pkg::CFG_SECOND_OFFSET:  r_off2 <= i_cfg_data;
                ifcd_pkg::CFG_THIRD_OFFSET:   r_off3 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < ifcd_pkg::WORD_COUNT; k++) begin
            end_x[k] = ifcd_pkg::CMP_W'(ifcd_pkg::word_end(k, r_off1, r_off2, r_off3));
        end
    end

    always_comb begin
        accept   = i_in_valid && !i_full;
        pos_x    = ifcd_pkg::CMP_W'(r_pos);
        max_x    = ifcd_pkg::CMP_W'(ifcd_pkg::MAX_FRAME_LEN);
        sum_go   = pos_x >= (ifcd_pkg::CMP_W'(r_cs) + ifcd_pkg::CMP_W'(2));
        sf_upd   = sum_go ? (r_sf + r_old) : r_sf;
        ss_upd   = sum_go ? (r_ss + sf_upd) : r_ss;
        in_range = pos_x < max_x;
        sums_ok  = (sf_upd == r_prev) && (ss_upd == i_frame_byte);

        short_frame = 1'b0;
        for (int k = 0; k < ifcd_pkg::WORD_COUNT; k++) begin
            if ((end_x[k] > pos_x) || (end_x[k] >= max_x)) begin
                short_frame = 1'b1;
            end
        end

        o_wr.data   = {i_frame_byte, r_asm};
        o_wr.commit = accept && i_frame_end;
        for (int k = 0; k < ifcd_pkg::WORD_COUNT; k++) begin
            o_wr.we[k] = accept && in_range && (end_x[k] == pos_x);
        end
        priority if (short_frame) begin
            o_wr.status = ifcd_pkg::ST_SHORT;
        end else if (!sums_ok) begin
            o_wr.status = ifcd_pkg::ST_BAD_SUM;
        end else begin
            o_wr.status = ifcd_pkg::ST_OK;
        end

        n_sf   = r_sf;
        n_ss   = r_ss;
        n_prev = r_prev;
        n_old  = r_old;
        n_pos  = r_pos;
        n_asm  = r_asm;
        if (accept) begin
            if (i_frame_end) begin
                n_sf   = '0;
                n_ss   = '0;
                n_prev = '0;
                n_old  = '0;
                n_pos  = '0;
                n_asm  = '0;
            end else begin
                n_sf   = sf_upd;
                n_ss   = ss_upd;
                n_old  = r_prev;
                n_prev = i_frame_byte;
                n_asm  = {i_frame_byte, r_asm[23:8]};
                n_pos  = in_range ? (r_pos + ifcd_pkg::POS_W'(1)) :
                                    ifcd_pkg::POS_W'(ifcd_pkg::MAX_FRAME_LEN);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf   <= '0;
            r_ss   <= '0;
            r_prev <= '0;
            r_old  <= '0;
            r_pos  <= '0;
            r_asm  <= '0;
        end else begin
            r_sf   <= n_sf;
            r_ss   <= n_ss;
            r_prev <= n_prev;
            r_old  <= n_old;
            r_pos  <= n_pos;
            r_asm  <= n_asm;
        end
    end

endmodule

// File: sv/ifcd_queue.sv
// frame slot queue between front and back: captured words and frame status
// depends on ifcd_pkg and the assertion macro header
`include "inertial_frame_checksum_decoder_core_assert.svh"

module ifcd_queue (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ifcd_pkg::t_wr_req                    i_wr,
    input  logic [ifcd_pkg::WORD_IDX_W-1:0]      i_rd_idx,
    input  logic                                 i_pop,
    output logic                                 o_full,
    output ifcd_pkg::t_head                      o_head,
    output logic [31:0]                          o_head_word
);

    logic [31:0]                 r_words  [ifcd_pkg::NUM_SLOTS][ifcd_pkg::WORD_COUNT];
    ifcd_pkg::t_status           r_status [ifcd_pkg::NUM_SLOTS];
    logic [ifcd_pkg::SLOT_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [ifcd_pkg::SLOT_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [ifcd_pkg::CNT_W-1:0]  r_count,  n_count;

    function automatic logic [ifcd_pkg::SLOT_W-1:0] ptr_inc(
        input logic [ifcd_pkg::SLOT_W-1:0] p);
        logic [ifcd_pkg::SLOT_W-1:0] last;
        last = ifcd_pkg::SLOT_W'(ifcd_pkg::NUM_SLOTS - 1);
        return (p == last) ? '0 : (p + ifcd_pkg::SLOT_W'(1));
    endfunction

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < ifcd_pkg::NUM_SLOTS; s++) begin
            for (int k = 0; k < ifcd_pkg::WORD_COUNT; k++) begin
                if (i_wr.we[k] && (r_wr_ptr == ifcd_pkg::SLOT_W'(s))) begin
                    r_words[s][k] <= i_wr.data;
                end
            end
            if (i_wr.commit && (r_wr_ptr == ifcd_pkg::SLOT_W'(s))) begin
                r_status[s] <= i_wr.status;
            end
        end
    end

    always_comb begin
        o_full        = r_count == ifcd_pkg::CNT_W'(ifcd_pkg::NUM_SLOTS);
        o_head.valid  = r_count != '0;
        o_head.status = r_status[r_rd_ptr];
        o_head_word   = r_words[r_rd_ptr][i_rd_idx];

        n_wr_ptr = i_wr.commit ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_wr.commit && !i_pop) begin
            n_count = r_count + ifcd_pkg::CNT_W'(1);
        end else if (!i_wr.commit && i_pop) begin
            n_count = r_count - ifcd_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `IFCD_ASSERT_NOW(a_no_commit_full, i_clk, i_rst_n, i_wr.commit, !o_full)
    `IFCD_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_head.valid)
    `IFCD_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= ifcd_pkg::CNT_W'(ifcd_pkg::NUM_SLOTS))

endmodule

// File: sv/ifcd_back.sv
// back end: turns queued frames into result items behind an output register
// depends on ifcd_pkg and the assertion macro header
`include "inertial_frame_checksum_decoder_core_assert.svh"

module ifcd_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ifcd_pkg::t_head                      i_head,
    input  logic [31:0]                          i_head_word,
    output logic [ifcd_pkg::WORD_IDX_W-1:0]      o_rd_idx,
    output logic                                 o_pop,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic [1:0]                           o_status,
    output logic [3:0]                           o_value_index,
    output logic signed [31:0]                   o_value,
    output logic                                 o_last
);

    logic [ifcd_pkg::WORD_IDX_W-1:0] r_idx, n_idx;
    logic                            r_valid, n_valid;
    ifcd_pkg::t_status               r_status;
    logic [3:0]                      r_index;
    logic [31:0]                     r_value;
    logic                            r_last;

    logic                            load;
    logic                            is_last_word;

    always_comb begin
        load         = i_head.valid && (!r_valid || !i_out_stall);
        is_last_word = r_idx == ifcd_pkg::WORD_IDX_W'(ifcd_pkg::WORD_COUNT - 1);
        o_rd_idx     = r_idx;
        o_pop        = load && ((i_head.status != ifcd_pkg::ST_OK) || is_last_word);

        n_idx = r_idx;
        if (load && (i_head.status == ifcd_pkg::ST_OK)) begin
            n_idx = is_last_word ? '0 : (r_idx + ifcd_pkg::WORD_IDX_W'(1));
        end

        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= i_head.status;
            if (i_head.status == ifcd_pkg::ST_OK) begin
                r_index <= 4'(r_idx);
                r_value <= i_head_word;
                r_last  <= is_last_word;
            end else begin
                r_index <= '0;
                r_value <= '0;
                r_last  <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_status      = r_status;
    assign o_value_index = r_index;
    assign o_value       = r_value;
    assign o_last        = r_last;

    `IFCD_ASSERT_NOW(a_status_alone, i_clk, i_rst_n, r_valid && (r_status != ifcd_pkg::ST_OK), r_last && (r_index == 4'd0))
    `IFCD_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, 1'b1, r_idx <= ifcd_pkg::WORD_IDX_W'(ifcd_pkg::WORD_COUNT - 1))
    `IFCD_ASSERT_NEXT(a_idx_mid_frame, i_clk, i_rst_n, load && (i_head.status == ifcd_pkg::ST_OK) && !is_last_word, r_idx != '0)

endmodule

// File: sv/inertial_frame_checksum_decoder_core.sv
// Frame checksum decoder: takes one frame byte per cycle on the input channel, with a stall
// asserted only while both frame slots of the internal queue hold frames whose final result
// has not yet moved into the output register. The front end folds the bytes from the
// checksum start into two 8-bit Fletcher-style sums and drops words straight into the
// current slot, so a frame is classified on the cycle its final byte is accepted. The
// back end drains a slot through an output register at one item per cycle unless stalled: a
// good frame gives ten words, any other frame a single status item. Configuration writes
// are always ready and apply from the next byte. There is no clearing pass after reset.
// depends on ifcd_pkg, ifcd_front, ifcd_queue and ifcd_back
module inertial_frame_checksum_decoder_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [7:0]                           i_frame_byte,
    input  logic                                 i_frame_end,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [1:0]                           o_status,
    output logic [3:0]                           o_value_index,
    output logic signed [31:0]                   o_value,
    output logic                                 o_last,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ifcd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [7:0]                           i_cfg_data
);

    ifcd_pkg::t_wr_req               wr;
    ifcd_pkg::t_head                 head;
    logic [31:0]                     head_word;
    logic [ifcd_pkg::WORD_IDX_W-1:0] rd_idx;
    logic                            pop;
    logic                            full;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = full;

    ifcd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_frame_byte (i_frame_byte),
        .i_frame_end  (i_frame_end),
        .i_full       (full),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_wr         (wr)
    );

    ifcd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (wr),
        .i_rd_idx    (rd_idx),
        .i_pop       (pop),
        .o_full      (full),
        .o_head      (head),
        .o_head_word (head_word)
    );

    ifcd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_head_word   (head_word),
        .o_rd_idx      (rd_idx),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_value_index (o_value_index),
        .o_value       (o_value),
        .o_last        (o_last)
    );

endmodule
